>>> hw/rtl/akrt_pkg.sv
// shared types and constants of the analog key rapid trigger block
package akrt_pkg;

  localparam int DEF_SAMPLES_PER_WINDOW = 16;
  localparam int DEF_AVERAGE_SHIFT      = 4;
  localparam int DEF_PRESS_RELOAD       = 1;

  localparam int VAL_W  = 12;
  localparam int CNT_W  = 8;
  localparam int CFG_IW = 3;
  localparam int DVD_W  = 21;
  localparam int DCNT_W = 5;

  localparam int K_LEFT   = 300;
  localparam int K_RIGHT  = 270;
  localparam int RECIP10  = 52429;
  localparam int RECIP_SH = 19;

  localparam logic [CFG_IW-1:0] REG_LEFT_MIN   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_LEFT_MAX   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_LEFT_HYST  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_LEFT_THR   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_RIGHT_MIN  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_RIGHT_MAX  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_RIGHT_HYST = 3'd6;
  localparam logic [CFG_IW-1:0] REG_RIGHT_THR  = 3'd7;

  localparam logic SEL_LEFT  = 1'b0;
  localparam logic SEL_RIGHT = 1'b1;

  typedef struct packed {
    logic acc;
    logic gap;
    logic div_start;
    logic div_sel;
    logic off_ld;
    logic clamp;
    logic mul;
    logic sum;
    logic trig;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

>>> hw/rtl/analog_key_rapid_trigger.sv
// top level of the analog key rapid trigger block
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_stall    in_sample_left, in_sample_right
//  out      output     out_valid/out_stall  averages, levels, counts
//  cfg      input      cfg_we               cfg_index, cfg_data
//
// a mid-window item is added to the window sums; the last item of a window
// starts the window computation, which runs the shared serial divider for
// both crosstalk offsets one after the other
// reset is synchronous, active low, and needs no clearing pass
// a result waits in the output register; the block stalls its input only
// while computing a window and while a new result cannot be loaded
module analog_key_rapid_trigger #(
  parameter int SAMPLES_PER_WINDOW = akrt_pkg::DEF_SAMPLES_PER_WINDOW,
  parameter int AVERAGE_SHIFT      = akrt_pkg::DEF_AVERAGE_SHIFT,
  parameter int PRESS_RELOAD       = akrt_pkg::DEF_PRESS_RELOAD
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [akrt_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [akrt_pkg::VAL_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [akrt_pkg::VAL_W-1:0]    in_sample_left,
  input  logic [akrt_pkg::VAL_W-1:0]    in_sample_right,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [akrt_pkg::VAL_W-1:0]    out_left_average,
  output logic [akrt_pkg::VAL_W-1:0]    out_right_average,
  output logic [akrt_pkg::VAL_W-1:0]    out_left_level,
  output logic [akrt_pkg::VAL_W-1:0]    out_right_level,
  output logic [akrt_pkg::CNT_W-1:0]    out_left_count,
  output logic [akrt_pkg::CNT_W-1:0]    out_right_count
);

  akrt_pkg::cmd_t cmd;
  akrt_pkg::sts_t sts;

  akrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  akrt_dp #(
    .SAMPLES_PER_WINDOW (SAMPLES_PER_WINDOW),
    .AVERAGE_SHIFT      (AVERAGE_SHIFT),
    .PRESS_RELOAD       (PRESS_RELOAD)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_sample_left    (in_sample_left),
    .in_sample_right   (in_sample_right),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_left_average  (out_left_average),
    .out_right_average (out_right_average),
    .out_left_level    (out_left_level),
    .out_right_level   (out_right_level),
    .out_left_count    (out_left_count),
    .out_right_count   (out_right_count)
  );

endmodule

>>> hw/rtl/akrt_div.sv
// restoring divider, one quotient bit per cycle
module akrt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [akrt_pkg::DVD_W-1:0]    dividend,
  input  logic [akrt_pkg::VAL_W-1:0]    divisor,
  output logic [akrt_pkg::DVD_W-1:0]    quotient,
  output logic                          done
);

  localparam int DW = akrt_pkg::DVD_W;
  localparam int VW = akrt_pkg::VAL_W;

  logic [DW-1:0]                 quo_r, quo_nxt;
  logic [VW-1:0]                 rem_r, rem_nxt;
  logic [VW-1:0]                 dsr_r;
  logic [akrt_pkg::DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [VW:0]                   rem_sh;
  logic [VW:0]                   rem_sub;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DW-1]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = akrt_pkg::DCNT_W'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_nxt = rem_sub[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == akrt_pkg::DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

>>> hw/rtl/akrt_dp.sv
// datapath: window sums, crosstalk, clamp, smoothing, trigger and output registers
module akrt_dp #(
  parameter int SAMPLES_PER_WINDOW = akrt_pkg::DEF_SAMPLES_PER_WINDOW,
  parameter int AVERAGE_SHIFT      = akrt_pkg::DEF_AVERAGE_SHIFT,
  parameter int PRESS_RELOAD       = akrt_pkg::DEF_PRESS_RELOAD
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  akrt_pkg::cmd_t                    cmd,
  output akrt_pkg::sts_t                    sts,
  input  logic                              cfg_we,
  input  logic [akrt_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [akrt_pkg::VAL_W-1:0]        cfg_data,
  input  logic [akrt_pkg::VAL_W-1:0]        in_sample_left,
  input  logic [akrt_pkg::VAL_W-1:0]        in_sample_right,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [akrt_pkg::VAL_W-1:0]        out_left_average,
  output logic [akrt_pkg::VAL_W-1:0]        out_right_average,
  output logic [akrt_pkg::VAL_W-1:0]        out_left_level,
  output logic [akrt_pkg::VAL_W-1:0]        out_right_level,
  output logic [akrt_pkg::CNT_W-1:0]        out_left_count,
  output logic [akrt_pkg::CNT_W-1:0]        out_right_count
);

  localparam int VW    = akrt_pkg::VAL_W;
  localparam int CW    = akrt_pkg::CNT_W;
  localparam int DW    = akrt_pkg::DVD_W;
  localparam int IDX_W = (SAMPLES_PER_WINDOW > 1) ? $clog2(SAMPLES_PER_WINDOW) : 1;
  localparam int SUM_W = VW + ((SAMPLES_PER_WINDOW > 1) ? $clog2(SAMPLES_PER_WINDOW) : 0);
  localparam int SV_W  = ((SUM_W > DW) ? SUM_W : DW) + 2;

  logic [VW-1:0] l_min_r, l_max_r, l_hyst_r, l_thr_r;
  logic [VW-1:0] r_min_r, r_max_r, r_hyst_r, r_thr_r;

  logic [SUM_W-1:0] sum_l_r, sum_r_r, sum_l_nxt, sum_r_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [SUM_W-1:0] avg_l_r, avg_r_r;
  logic [DW-1:0]    prod_l_r, prod_r_r;
  logic             rpos_l_r, rpos_r_r;
  logic [DW-1:0]    off_l_r, off_r_r;
  logic [VW-1:0]    a_l_r, a_r_r;
  logic [VW-1:0]    qo_l_r, qo_r_r, qn_l_r, qn_r_r;
  logic             primed_r;
  logic [VW-1:0]    sm_l_r, sm_r_r;
  logic [CW-1:0]    pr_l_r, pr_r_r;
  logic [VW-1:0]    pk_l_r, vl_l_r, pk_r_r, vl_r_r;
  logic             ov_r;

  logic [VW-1:0]    gap_l, gap_r;
  logic [DW-1:0]    div_q;
  logic             div_done;
  logic [DW-1:0]    div_dvd;
  logic [VW-1:0]    div_dsr;
  logic             last;

  assign last = (idx_r == IDX_W'(SAMPLES_PER_WINDOW - 1));
  assign sum_l_nxt = sum_l_r + SUM_W'(in_sample_left);
  assign sum_r_nxt = sum_r_r + SUM_W'(in_sample_right);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_min_r <= '0; l_max_r <= 12'd4095; l_hyst_r <= 12'd100; l_thr_r <= 12'd2048;
      r_min_r <= '0; r_max_r <= 12'd4095; r_hyst_r <= 12'd100; r_thr_r <= 12'd2048;
    end else if (cfg_we) begin
      unique case (cfg_index)
        akrt_pkg::REG_LEFT_MIN:   l_min_r  <= cfg_data;
        akrt_pkg::REG_LEFT_MAX:   l_max_r  <= cfg_data;
        akrt_pkg::REG_LEFT_HYST:  l_hyst_r <= cfg_data;
        akrt_pkg::REG_LEFT_THR:   l_thr_r  <= cfg_data;
        akrt_pkg::REG_RIGHT_MIN:  r_min_r  <= cfg_data;
        akrt_pkg::REG_RIGHT_MAX:  r_max_r  <= cfg_data;
        akrt_pkg::REG_RIGHT_HYST: r_hyst_r <= cfg_data;
        akrt_pkg::REG_RIGHT_THR:  r_thr_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [VW-1:0] gap_of(input logic [VW-1:0] kmax,
                                           input logic [SUM_W-1:0] avg);
    logic [SUM_W:0] d;
    begin
      d = {1'b0, SUM_W'(kmax)} - {1'b0, avg};
      if (SUM_W'(kmax) > avg) gap_of = VW'(d);
      else gap_of = '0;
    end
  endfunction

  assign gap_l = gap_of(l_max_r, avg_l_r);
  assign gap_r = gap_of(r_max_r, avg_r_r);

  assign div_dvd = (cmd.div_sel == akrt_pkg::SEL_LEFT) ? prod_l_r : prod_r_r;
  assign div_dsr = (cmd.div_sel == akrt_pkg::SEL_LEFT) ? (r_max_r - r_min_r)
                                                       : (l_max_r - l_min_r);

  akrt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (div_q),
    .done     (div_done)
  );

  function automatic logic [VW-1:0] clamp_of(input logic [SUM_W-1:0] avg,
                                             input logic [DW-1:0] off,
                                             input logic [VW-1:0] lo,
                                             input logic [VW-1:0] hi);
    logic signed [SV_W-1:0] v;
    begin
      v = $signed(SV_W'(avg)) - $signed(SV_W'(off));
      if (v < $signed(SV_W'(lo))) clamp_of = lo;
      else if (v > $signed(SV_W'(hi))) clamp_of = hi;
      else clamp_of = v[VW-1:0];
    end
  endfunction

  function automatic logic [VW-1:0] div10(input logic [15:0] x);
    logic [31:0] p;
    begin
      p = x * 16'(akrt_pkg::RECIP10);
      div10 = VW'(p >> akrt_pkg::RECIP_SH);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_l_r <= '0; sum_r_r <= '0; idx_r <= '0;
      primed_r <= 1'b0;
      sm_l_r <= '0; sm_r_r <= '0;
      pr_l_r <= '0; pr_r_r <= '0;
      pk_l_r <= '0; vl_l_r <= '0; pk_r_r <= '0; vl_r_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (cmd.acc) begin
        if (last) begin
          sum_l_r <= '0; sum_r_r <= '0; idx_r <= '0;
        end else begin
          sum_l_r <= sum_l_nxt; sum_r_r <= sum_r_nxt; idx_r <= idx_r + 1'b1;
        end
      end
      if (cmd.sum) begin
        primed_r <= 1'b1;
        if (primed_r) begin
          sm_l_r <= qo_l_r + qn_l_r;
          sm_r_r <= qo_r_r + qn_r_r;
        end else begin
          sm_l_r <= a_l_r;
          sm_r_r <= a_r_r;
        end
      end
      if (cmd.trig) begin
        if (pr_l_r == '0) begin
          if (sm_l_r > pk_l_r) begin
            pk_l_r <= sm_l_r;
          end else if ($signed({2'b0, sm_l_r}) < $signed({2'b0, pk_l_r}) -
                       $signed({2'b0, l_hyst_r}) && sm_l_r < l_thr_r) begin
            pr_l_r <= CW'(PRESS_RELOAD);
            vl_l_r <= sm_l_r;
          end
        end else begin
          if (sm_l_r < vl_l_r) begin
            vl_l_r <= sm_l_r;
          end else if ({1'b0, sm_l_r} > {1'b0, vl_l_r} + {1'b0, l_hyst_r}) begin
            pr_l_r <= pr_l_r - 1'b1;
            pk_l_r <= sm_l_r;
          end
        end
        if (pr_r_r == '0) begin
          if (sm_r_r > pk_r_r) begin
            pk_r_r <= sm_r_r;
          end else if ($signed({2'b0, sm_r_r}) < $signed({2'b0, pk_r_r}) -
                       $signed({2'b0, r_hyst_r}) && sm_r_r < r_thr_r) begin
            pr_r_r <= CW'(PRESS_RELOAD);
            vl_r_r <= sm_r_r;
          end
        end else begin
          if (sm_r_r < vl_r_r) begin
            vl_r_r <= sm_r_r;
          end else if ({1'b0, sm_r_r} > {1'b0, vl_r_r} + {1'b0, r_hyst_r}) begin
            pr_r_r <= pr_r_r - 1'b1;
            pk_r_r <= sm_r_r;
          end
        end
      end
      if (cmd.load) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && last) begin
      avg_l_r <= sum_l_nxt >> AVERAGE_SHIFT;
      avg_r_r <= sum_r_nxt >> AVERAGE_SHIFT;
    end
    if (cmd.gap) begin
      prod_l_r <= DW'(akrt_pkg::K_LEFT * gap_r);
      prod_r_r <= DW'(akrt_pkg::K_RIGHT * gap_l);
      rpos_l_r <= r_max_r > r_min_r;
      rpos_r_r <= l_max_r > l_min_r;
    end
    if (cmd.off_ld) begin
      if (cmd.div_sel == akrt_pkg::SEL_LEFT) off_l_r <= rpos_l_r ? div_q : '0;
      else off_r_r <= rpos_r_r ? div_q : '0;
    end
    if (cmd.clamp) begin
      a_l_r <= clamp_of(avg_l_r, off_l_r, l_min_r, l_max_r);
      a_r_r <= clamp_of(avg_r_r, off_r_r, r_min_r, r_max_r);
    end
    if (cmd.mul) begin
      qo_l_r <= div10(16'(sm_l_r));
      qo_r_r <= div10(16'(sm_r_r));
      qn_l_r <= div10({1'b0, a_l_r, 3'b0} + 16'(a_l_r));
      qn_r_r <= div10({1'b0, a_r_r, 3'b0} + 16'(a_r_r));
    end
    if (cmd.load) begin
      out_left_average  <= a_l_r;
      out_right_average <= a_r_r;
      out_left_level    <= sm_l_r;
      out_right_level   <= sm_r_r;
      out_left_count    <= pr_l_r;
      out_right_count   <= pr_r_r;
    end
  end

  assign out_valid    = ov_r;
  assign sts.last     = last;
  assign sts.div_done = div_done;
  assign sts.out_busy = ov_r && out_stall;

endmodule

>>> hw/rtl/akrt_ctrl.sv
// controller state machine sequencing one window result
module akrt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  akrt_pkg::sts_t   sts,
  output akrt_pkg::cmd_t   cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GAP   = 4'd1;
  localparam logic [3:0] S_DL    = 4'd2;
  localparam logic [3:0] S_DLW   = 4'd3;
  localparam logic [3:0] S_DR    = 4'd4;
  localparam logic [3:0] S_DRW   = 4'd5;
  localparam logic [3:0] S_CLAMP = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_SUM   = 4'd8;
  localparam logic [3:0] S_TRIG  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.acc = in_valid;
        if (in_valid && sts.last) state_nxt = S_GAP;
      end
      S_GAP: begin
        cmd.gap = 1'b1;
        state_nxt = S_DL;
      end
      S_DL: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = akrt_pkg::SEL_LEFT;
        state_nxt = S_DLW;
      end
      S_DLW: begin
        cmd.div_sel = akrt_pkg::SEL_LEFT;
        if (sts.div_done) begin
          cmd.off_ld = 1'b1;
          state_nxt = S_DR;
        end
      end
      S_DR: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = akrt_pkg::SEL_RIGHT;
        state_nxt = S_DRW;
      end
      S_DRW: begin
        cmd.div_sel = akrt_pkg::SEL_RIGHT;
        if (sts.div_done) begin
          cmd.off_ld = 1'b1;
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        state_nxt = S_TRIG;
      end
      S_TRIG: begin
        cmd.trig = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
